FILE: rtl/tsm_pkg.sv
// ----------------------------------------------------------------------------
// tsm_pkg: shared types and constants for the texture SRT matrix block
// Item and result structs, queue entry, transform model codes.
// ----------------------------------------------------------------------------
package tsm_pkg;

    localparam int DEF_SINE_TABLE_DEPTH = 1024;
    localparam int DEF_FRACTION_BITS    = 16;
    // Index field sized for the largest supported table (16384 + 1 entries)
    localparam int IDX_W                = 15;

    typedef enum logic [1:0] {
        MODEL_BASIC = 2'd0,
        MODEL_TOOL1 = 2'd1,
        MODEL_TOOL2 = 2'd2,
        MODEL_TOOL3 = 2'd3
    } t_model;

    typedef struct packed {
        logic signed [23:0] scale_s;
        logic signed [23:0] scale_t;
        logic        [15:0] angle;
        logic signed [23:0] shift_s;
        logic signed [23:0] shift_t;
    } t_item;

    typedef struct packed {
        logic signed [31:0] s_from_s;
        logic signed [31:0] s_from_t;
        logic signed [31:0] s_offset;
        logic signed [31:0] t_from_s;
        logic signed [31:0] t_from_t;
        logic signed [31:0] t_offset;
        logic               clipped;
    } t_result;

    // Classified item as it travels from front to back
    typedef struct packed {
        logic [IDX_W-1:0]   sin_idx;
        logic               sin_neg;
        logic [IDX_W-1:0]   cos_idx;
        logic               cos_neg;
        t_model             model;
        logic signed [23:0] scale_s;
        logic signed [23:0] scale_t;
        logic signed [23:0] shift_s;
        logic signed [23:0] shift_t;
    } t_task;

    // Queue status toward the front
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

FILE: rtl/tsm_front.sv
// ----------------------------------------------------------------------------
// tsm_front: item classification
// Splits the angle into quadrant and phase for sine and cosine and forms
// the quarter-wave table indexes and signs.
// ----------------------------------------------------------------------------
module tsm_front import tsm_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
    input  t_item  i_item,
    input  t_model i_model,
    output t_task  o_task
);

    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);

    logic [15:0] w_cos_ang;
    logic [14:0] w_u_s;
    logic [14:0] w_u_c;
    logic [29:0] w_raw_s;
    logic [29:0] w_raw_c;
    logic [15:0] w_i_s;
    logic [15:0] w_i_c;

    // u in [0,16384]; index = (u*DEPTH + 8192) >> 14, clamped to DEPTH
    always_comb begin
        w_cos_ang = i_item.angle + 16'd16384;
        w_u_s = i_item.angle[14] ? 15'(15'd16384 - {1'b0, i_item.angle[13:0]})
                                 : {1'b0, i_item.angle[13:0]};
        w_u_c = w_cos_ang[14] ? 15'(15'd16384 - {1'b0, w_cos_ang[13:0]})
                              : {1'b0, w_cos_ang[13:0]};
        w_raw_s = 30'(w_u_s) * 30'(SINE_TABLE_DEPTH) + 30'd8192;
        w_raw_c = 30'(w_u_c) * 30'(SINE_TABLE_DEPTH) + 30'd8192;
        w_i_s = w_raw_s[29:14];
        w_i_c = w_raw_c[29:14];
        if (w_i_s > 16'(SINE_TABLE_DEPTH)) begin
            w_i_s = 16'(SINE_TABLE_DEPTH);
        end
        if (w_i_c > 16'(SINE_TABLE_DEPTH)) begin
            w_i_c = 16'(SINE_TABLE_DEPTH);
        end

        o_task.sin_idx = IDX_W'(w_i_s[IW-1:0]);
        o_task.sin_neg = i_item.angle[15];
        o_task.cos_idx = IDX_W'(w_i_c[IW-1:0]);
        o_task.cos_neg = w_cos_ang[15];
        o_task.model   = i_model;
        o_task.scale_s = i_item.scale_s;
        o_task.scale_t = i_item.scale_t;
        o_task.shift_s = i_item.shift_s;
        o_task.shift_t = i_item.shift_t;
    end

endmodule

FILE: rtl/tsm_queue.sv
// ----------------------------------------------------------------------------
// tsm_queue: two-entry queue between front and back
// Register-based FIFO; push and pop in the same cycle are allowed.
// ----------------------------------------------------------------------------
module tsm_queue import tsm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_task  i_task,
    input  logic   i_pop,
    output t_task  o_task,
    output t_qstat o_stat
);

    t_task      r_mem [0:1];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_task;
        end
    end

    assign o_task       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

endmodule

FILE: rtl/tsm_back.sv
// ----------------------------------------------------------------------------
// tsm_back: matrix datapath
// Four stages: table read, first products, second products, sums and
// saturation into the result register.
// ----------------------------------------------------------------------------
module tsm_back import tsm_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
    parameter int FRACTION_BITS    = DEF_FRACTION_BITS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_task   i_task,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int TW = FRACTION_BITS + 1;
    localparam int MW = 26;
    localparam int PW = 2 * MW;
    localparam int SW = PW + 4;
    localparam logic signed [MW-1:0] HALF_Q = MW'(2 ** (FRACTION_BITS - 1));
    localparam logic signed [SW-1:0] HALF_S = SW'(2 ** (FRACTION_BITS - 1));
    localparam logic signed [SW-1:0] ONE_S  = SW'(2 ** FRACTION_BITS);
    localparam logic signed [SW-1:0] MAX32  = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] MIN32  = SW'(-64'sd2147483648);

    typedef logic [TW-1:0] t_tab [0:SINE_TABLE_DEPTH];

    // Quarter-wave sine, Taylor series to x^17 in unsigned Q30
    function automatic t_tab build_tab();
        t_tab               tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = (64'd1686629713 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            for (int k = 1; k <= 8; k++) begin
                term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (sum + (64'sd1 <<< (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);
            if (v > (64'sd1 <<< FRACTION_BITS)) begin
                v = 64'sd1 <<< FRACTION_BITS;
            end
            tab[i] = TW'(v);
        end
        return tab;
    endfunction

    localparam t_tab SINE_TAB = build_tab();

    // Fixed-point multiply, rounding half up
    function automatic logic signed [PW-1:0] mul_q(input logic signed [MW-1:0] a,
                                                   input logic signed [MW-1:0] b);
        logic signed [PW-1:0] pr;
        pr = PW'(a) * PW'(b);
        return (pr + PW'(HALF_Q)) >>> FRACTION_BITS;
    endfunction

    // ---- stage 1: table read
    logic          r1_v;
    logic [TW-1:0] r1_sin_mag;
    logic [TW-1:0] r1_cos_mag;
    t_task         r1_task;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_sin_mag <= SINE_TAB[i_task.sin_idx[IW-1:0]];
        r1_cos_mag <= SINE_TAB[i_task.cos_idx[IW-1:0]];
        r1_task    <= i_task;
    end

    // ---- stage 2: first products
    logic signed [MW-1:0] w_sn;
    logic signed [MW-1:0] w_cs;
    logic signed [MW-1:0] w_ss;
    logic signed [MW-1:0] w_st;

    always_comb begin
        w_sn = signed'(MW'(r1_sin_mag));
        w_cs = signed'(MW'(r1_cos_mag));
        if (r1_task.sin_neg) begin
            w_sn = -w_sn;
        end
        if (r1_task.cos_neg) begin
            w_cs = -w_cs;
        end
        w_ss = MW'(r1_task.scale_s);
        w_st = MW'(r1_task.scale_t);
    end

    logic                 r2_v;
    t_task                r2_task;
    logic signed [MW-1:0] r2_psc;
    logic signed [MW-1:0] r2_pss;
    logic signed [MW-1:0] r2_pts;
    logic signed [MW-1:0] r2_ptc;
    logic signed [MW-1:0] r2_hs;
    logic signed [MW-1:0] r2_hc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_task <= r1_task;
        r2_psc  <= MW'(mul_q(w_ss, w_cs));
        r2_pss  <= MW'(mul_q(w_ss, w_sn));
        r2_pts  <= MW'(mul_q(w_st, w_sn));
        r2_ptc  <= MW'(mul_q(w_st, w_cs));
        r2_hs   <= MW'(mul_q(HALF_Q, w_sn));
        r2_hc   <= MW'(mul_q(HALF_Q, w_cs));
    end

    // ---- stage 3: second products, operands picked by model
    logic signed [MW-1:0] w_a [0:3];
    logic signed [MW-1:0] w_b [0:3];
    logic signed [MW-1:0] w_ts;
    logic signed [MW-1:0] w_tt;

    always_comb begin
        w_ts = MW'(r2_task.shift_s);
        w_tt = MW'(r2_task.shift_t);
        for (int j = 0; j < 4; j++) begin
            w_a[j] = '0;
            w_b[j] = '0;
        end
        case (r2_task.model)
            MODEL_BASIC: begin
                w_a[0] = r2_psc;  w_b[0] = HALF_Q;
                w_a[1] = -r2_pss; w_b[1] = HALF_Q;
                w_a[2] = r2_pts;  w_b[2] = HALF_Q;
                w_a[3] = r2_ptc;  w_b[3] = HALF_Q;
            end
            MODEL_TOOL1: begin
                w_a[0] = MW'(r2_task.scale_s);
                w_b[0] = -r2_hs - r2_hc + HALF_Q - w_ts;
                w_a[1] = MW'(r2_task.scale_t);
                w_b[1] = r2_hs - r2_hc - HALF_Q + w_tt;
            end
            MODEL_TOOL2: begin
                w_a[0] = r2_psc; w_b[0] = w_ts + HALF_Q;
                w_a[1] = r2_pss; w_b[1] = w_tt - HALF_Q;
                w_a[2] = r2_pts; w_b[2] = w_ts + HALF_Q;
                // offset uses scale S here, as the source convention does
                w_a[3] = r2_psc; w_b[3] = w_tt - HALF_Q;
            end
            MODEL_TOOL3: begin
                w_a[0] = r2_psc; w_b[0] = w_ts;
                w_a[1] = r2_pss; w_b[1] = w_tt;
                w_a[2] = r2_pts; w_b[2] = w_ts;
                w_a[3] = r2_ptc; w_b[3] = w_tt;
            end
            default: begin
                w_a[0] = '0;
            end
        endcase
    end

    logic                 r3_v;
    t_task                r3_task;
    logic signed [MW-1:0] r3_psc;
    logic signed [MW-1:0] r3_pss;
    logic signed [MW-1:0] r3_pts;
    logic signed [MW-1:0] r3_ptc;
    logic signed [PW-1:0] r3_k [0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_task <= r2_task;
        r3_psc  <= r2_psc;
        r3_pss  <= r2_pss;
        r3_pts  <= r2_pts;
        r3_ptc  <= r2_ptc;
        for (int j = 0; j < 4; j++) begin
            r3_k[j] <= mul_q(w_a[j], w_b[j]);
        end
    end

    // ---- stage 4: sums and saturation
    logic signed [SW-1:0] w_m [0:5];
    logic signed [SW-1:0] w_k [0:3];
    logic signed [SW-1:0] w_sc;
    logic signed [SW-1:0] w_sss;
    logic signed [SW-1:0] w_tss;
    logic signed [SW-1:0] w_tc;
    logic signed [SW-1:0] w_sh_s;
    logic signed [SW-1:0] w_sh_t;
    logic signed [31:0]   w_sat [0:5];
    logic                 w_clip;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_k[j] = SW'(r3_k[j]);
        end
        w_sc   = SW'(r3_psc);
        w_sss  = SW'(r3_pss);
        w_tss  = SW'(r3_pts);
        w_tc   = SW'(r3_ptc);
        w_sh_s = SW'(r3_task.shift_s);
        w_sh_t = SW'(r3_task.shift_t);
        case (r3_task.model)
            MODEL_BASIC: begin
                w_m[0] = w_sc;  w_m[1] = -w_sss;
                w_m[2] = w_sh_s + HALF_S - (w_k[0] + w_k[1]);
                w_m[3] = w_tss; w_m[4] = w_tc;
                w_m[5] = w_sh_t + HALF_S - (w_k[2] + w_k[3]);
            end
            MODEL_TOOL1: begin
                w_m[0] = w_sc;   w_m[1] = w_sss; w_m[2] = w_k[0];
                w_m[3] = -w_tss; w_m[4] = w_tc;  w_m[5] = w_k[1] + ONE_S;
            end
            MODEL_TOOL2: begin
                w_m[0] = w_sc;   w_m[1] = w_sss;
                w_m[2] = -w_k[0] + w_k[1] + HALF_S;
                w_m[3] = -w_tss; w_m[4] = w_tc;
                w_m[5] = w_k[2] + w_k[3] + HALF_S;
            end
            default: begin
                w_m[0] = w_sc;  w_m[1] = -w_sss;
                w_m[2] = w_sss - w_k[0] - w_k[1];
                w_m[3] = w_tss; w_m[4] = w_tc;
                w_m[5] = -w_tc - w_k[2] + w_k[3] + ONE_S;
            end
        endcase
        w_clip = 1'b0;
        for (int j = 0; j < 6; j++) begin
            if (w_m[j] > MAX32) begin
                w_sat[j] = 32'sh7fffffff;
                w_clip   = 1'b1;
            end else if (w_m[j] < MIN32) begin
                w_sat[j] = 32'sh80000000;
                w_clip   = 1'b1;
            end else begin
                w_sat[j] = w_m[j][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result.s_from_s <= w_sat[0];
        o_result.s_from_t <= w_sat[1];
        o_result.s_offset <= w_sat[2];
        o_result.t_from_s <= w_sat[3];
        o_result.t_from_t <= w_sat[4];
        o_result.t_offset <= w_sat[5];
        o_result.clipped  <= w_clip;
    end

endmodule

FILE: rtl/texture_srt_matrix.sv
// ----------------------------------------------------------------------------
// texture_srt_matrix: 2x3 affine texture matrix from scale, rotation, shift
// Front classifies the angle, a short queue decouples it from the back
// datapath, which produces the six saturated coefficients.
// ----------------------------------------------------------------------------
// Usage: one item can be taken every cycle. An item is transferred when
// start is high and busy is low; its result appears on o_result with
// o_strobe high for one cycle, after the queue slot written at the transfer
// edge, then table read, two multiply stages, sum and saturate. The
// receiver cannot stall, so the back never holds and busy only rises if
// the two-entry queue were full, which with one pop per cycle it never is
// after reset. transform_model is written through i_cfg_we/i_cfg_data
// while no item is in flight, a duty of the user that the block does not
// enforce; the model travels with each item, so a write only affects
// items transferred after it. No clearing pass: the sine table is a
// constant ROM of SINE_TABLE_DEPTH+1 entries.
// ----------------------------------------------------------------------------
module texture_srt_matrix import tsm_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
    parameter int FRACTION_BITS    = DEF_FRACTION_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_item      i_item,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data,
    output logic       o_strobe,
    output t_result    o_result
);

    t_model r_model;
    t_task  w_front_task;
    t_task  w_q_task;
    t_qstat w_qstat;
    logic   w_push;
    logic   w_pop;

    // transform model register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model <= MODEL_BASIC;
        end else if (i_cfg_we) begin
            r_model <= t_model'(i_cfg_data);
        end
    end

    assign busy   = w_qstat.full;
    assign w_push = start && !busy;
    // back never stalls: pop whenever something is queued
    assign w_pop  = !w_qstat.empty;

    tsm_front #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_front (
        .i_item (i_item),
        .i_model(r_model),
        .o_task (w_front_task)
    );

    tsm_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_task (w_front_task),
        .i_pop  (w_pop),
        .o_task (w_q_task),
        .o_stat (w_qstat)
    );

    tsm_back #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pop),
        .i_task  (w_q_task),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

endmodule

FILE: rtl/tsm_checker.sv
// ----------------------------------------------------------------------------
// tsm_checker: port-level checks for texture_srt_matrix
// Latency, result origin and clip flag consistency.
// ----------------------------------------------------------------------------
module tsm_checker import tsm_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_strobe,
    input t_result o_result
);

    // strobe follows the transfer through the queue slot, table read, product stages and sums
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_strobe)
        else $error("transfer without result five edges later");

    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 5))
        else $error("result without matching transfer");

    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.clipped) |->
            (o_result.s_from_s == 32'sh7fffffff || o_result.s_from_s == 32'sh80000000 ||
             o_result.s_from_t == 32'sh7fffffff || o_result.s_from_t == 32'sh80000000 ||
             o_result.s_offset == 32'sh7fffffff || o_result.s_offset == 32'sh80000000 ||
             o_result.t_from_s == 32'sh7fffffff || o_result.t_from_s == 32'sh80000000 ||
             o_result.t_from_t == 32'sh7fffffff || o_result.t_from_t == 32'sh80000000 ||
             o_result.t_offset == 32'sh7fffffff || o_result.t_offset == 32'sh80000000))
        else $error("clip flag without a saturated coefficient");

endmodule

bind texture_srt_matrix tsm_checker u_tsm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_strobe(o_strobe),
    .o_result(o_result)
);

FILE: bench/texture_srt_matrix_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_srt_matrix_tb: self-checking bench for the texture SRT matrix block
// Drives directed and random parameter sets under every transform model,
// predicts each coefficient row in fixed point and compares each strobed
// result with the oldest prediction.
// ----------------------------------------------------------------------------
module texture_srt_matrix_tb;
    import tsm_pkg::*;

    localparam int DEPTH    = DEF_SINE_TABLE_DEPTH;
    localparam int FB       = DEF_FRACTION_BITS;
    localparam longint HALF = 64'sd1 << (FB - 1);
    localparam longint ONE  = 64'sd1 << FB;
    localparam longint CYCLE_LIMIT = 200000;
    localparam int N_RANDOM = 1350;
    // Stage count of the back datapath; drain waits a margin beyond it
    localparam int LATENCY  = 4;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_item   i_item = '0;
    logic    i_cfg_we = 1'b0;
    logic [1:0] i_cfg_data = '0;
    logic    o_strobe;
    t_result o_result;

    texture_srt_matrix u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: sine table and the model the bench believes is set
    // ------------------------------------------------------------------
    longint sine_rom [0:DEPTH];
    t_model cur_model = MODEL_BASIC;
    t_result matrix_q[$];
    bit      failed = 1'b0;
    longint  cycles = 0;
    int      idle_pct = 0;

    task automatic build_sine_rom();
        longint unsigned x, x2, term;
        longint sum, v;
        for (int i = 0; i <= DEPTH; i++) begin
            x = (64'd1686629713 * i) / DEPTH;
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            for (int k = 1; k <= 8; k++) begin
                term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
                if (k % 2) sum -= term; else sum += term;
            end
            if (sum < 0) sum = 0;
            v = (sum + (64'sd1 << (29 - FB))) >>> (30 - FB);
            if (v > ONE) v = ONE;
            sine_rom[i] = v;
        end
    endtask

    function automatic longint quarter_wave(int unsigned u);
        int unsigned idx;
        idx = (u * DEPTH + 8192) >> 14;
        if (idx > DEPTH) idx = DEPTH;
        return sine_rom[idx];
    endfunction

    function automatic longint bam_sine(logic [15:0] a);
        longint m;
        m = a[14] ? quarter_wave(16384 - a[13:0]) : quarter_wave(a[13:0]);
        return a[15] ? -m : m;
    endfunction

    // Round half up, arithmetic shift floors for negatives
    function automatic longint fx_mul(longint a, longint b);
        return (a * b + HALF) >>> FB;
    endfunction

    function automatic logic signed [31:0] sat32(longint v, inout logic clip);
        if (v > 64'sd2147483647) begin
            clip = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            clip = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_result predict_matrix(t_item it, t_model mdl);
        longint ss, st, ts, tt, sn, cs;
        longint m[6];
        logic clip;
        t_result r;
        ss = it.scale_s; st = it.scale_t; ts = it.shift_s; tt = it.shift_t;
        sn = bam_sine(it.angle);
        cs = bam_sine(it.angle + 16'd16384);
        clip = 1'b0;
        case (mdl)
            MODEL_TOOL1: begin
                m[0] = fx_mul(ss, cs);
                m[1] = fx_mul(ss, sn);
                m[2] = fx_mul(ss, -fx_mul(HALF, sn) - fx_mul(HALF, cs) + HALF - ts);
                m[3] = -fx_mul(st, sn);
                m[4] = fx_mul(st, cs);
                m[5] = fx_mul(st, fx_mul(HALF, sn) - fx_mul(HALF, cs) - HALF + tt) + ONE;
            end
            MODEL_TOOL2: begin
                m[0] = fx_mul(ss, cs);
                m[1] = fx_mul(ss, sn);
                m[2] = -fx_mul(fx_mul(ss, cs), ts + HALF)
                       + fx_mul(fx_mul(ss, sn), tt - HALF) + HALF;
                m[3] = -fx_mul(st, sn);
                m[4] = fx_mul(st, cs);
                // T offset deliberately picks up scale_s in its second term
                m[5] = fx_mul(fx_mul(st, sn), ts + HALF)
                       + fx_mul(fx_mul(ss, cs), tt - HALF) + HALF;
            end
            MODEL_TOOL3: begin
                m[0] = fx_mul(ss, cs);
                m[1] = -fx_mul(ss, sn);
                m[2] = fx_mul(ss, sn) - fx_mul(fx_mul(ss, cs), ts)
                       - fx_mul(fx_mul(ss, sn), tt);
                m[3] = fx_mul(st, sn);
                m[4] = fx_mul(st, cs);
                m[5] = -fx_mul(st, cs) - fx_mul(fx_mul(st, sn), ts)
                       + fx_mul(fx_mul(st, cs), tt) + ONE;
            end
            default: begin
                m[0] = fx_mul(ss, cs);
                m[1] = -fx_mul(ss, sn);
                m[2] = ts + HALF - (fx_mul(m[0], HALF) + fx_mul(m[1], HALF));
                m[3] = fx_mul(st, sn);
                m[4] = fx_mul(st, cs);
                m[5] = tt + HALF - (fx_mul(m[3], HALF) + fx_mul(m[4], HALF));
            end
        endcase
        r.s_from_s = sat32(m[0], clip);
        r.s_from_t = sat32(m[1], clip);
        r.s_offset = sat32(m[2], clip);
        r.t_from_s = sat32(m[3], clip);
        r.t_from_t = sat32(m[4], clip);
        r.t_offset = sat32(m[5], clip);
        r.clipped  = clip;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every strobe pops the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result exp_r;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached", $time);
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n && o_strobe) begin
            if (matrix_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_result);
                failed = 1'b1;
            end else begin
                exp_r = matrix_q.pop_front();
                if (o_result.s_from_s !== exp_r.s_from_s)
                    $display("%0t: s_from_s exp %0d got %0d", $time,
                             exp_r.s_from_s, o_result.s_from_s);
                if (o_result.s_from_t !== exp_r.s_from_t)
                    $display("%0t: s_from_t exp %0d got %0d", $time,
                             exp_r.s_from_t, o_result.s_from_t);
                if (o_result.s_offset !== exp_r.s_offset)
                    $display("%0t: s_offset exp %0d got %0d", $time,
                             exp_r.s_offset, o_result.s_offset);
                if (o_result.t_from_s !== exp_r.t_from_s)
                    $display("%0t: t_from_s exp %0d got %0d", $time,
                             exp_r.t_from_s, o_result.t_from_s);
                if (o_result.t_from_t !== exp_r.t_from_t)
                    $display("%0t: t_from_t exp %0d got %0d", $time,
                             exp_r.t_from_t, o_result.t_from_t);
                if (o_result.t_offset !== exp_r.t_offset)
                    $display("%0t: t_offset exp %0d got %0d", $time,
                             exp_r.t_offset, o_result.t_offset);
                if (o_result.clipped !== exp_r.clipped)
                    $display("%0t: clipped exp %0b got %0b", $time,
                             exp_r.clipped, o_result.clipped);
                if (o_result !== exp_r) failed = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Hold one item until it transfers; optional random idle cycles first.
    // start stays high across back-to-back transfers and drops only for idle cycles.
    task automatic send_item(t_item it);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        matrix_q.push_back(predict_matrix(it, cur_model));
    endtask

    // Drain the pipe; write_model uses it to write the model register while idle
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (matrix_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_model(t_model mdl);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= mdl;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_model = mdl;
        @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_fx();
        case ($urandom_range(5))
            0: return 24'($urandom());                     // full pattern
            1: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            2: return 24'($urandom_range(2 * ONE) - ONE);  // typical scale
            default: return 24'($urandom_range(8 * ONE) - 4 * ONE);
        endcase
    endfunction

    function automatic t_item rand_item();
        t_item it;
        it.scale_s = rand_fx();
        it.scale_t = rand_fx();
        it.angle   = ($urandom_range(7) == 0) ? 16'($urandom_range(3) << 14)
                                              : 16'($urandom());
        it.shift_s = rand_fx();
        it.shift_t = rand_fx();
        return it;
    endfunction

    // Directed rows: extremes, quadrant boundaries, saturation
    typedef struct {
        t_item   it;
        bit      has_exp;
        t_result exp_r;
    } t_row;

    t_row rows[$];

    function automatic t_item mk(longint ss, longint st, int a, longint ts, longint tt);
        t_item it;
        it.scale_s = 24'(ss); it.scale_t = 24'(st); it.angle = 16'(a);
        it.shift_s = 24'(ts); it.shift_t = 24'(tt);
        return it;
    endfunction

    task automatic add_row(t_item it, bit has_exp, t_result er);
        t_row r;
        r.it = it; r.has_exp = has_exp; r.exp_r = er;
        rows.push_back(r);
    endtask

    initial begin
        t_result er;
        t_model models[4];
        t_item  it;
        build_sine_rom();
        models = '{MODEL_BASIC, MODEL_TOOL1, MODEL_TOOL2, MODEL_TOOL3};

        // Zero input under the basic model after reset: zero matrix, offsets at one half
        er = '0; er.s_offset = HALF; er.t_offset = HALF;
        add_row(mk(0, 0, 0, 0, 0), 1'b1, er);
        // Unit scale, no rotation: identity matrix with zero offsets
        er = '0; er.s_from_s = ONE; er.t_from_t = ONE;
        add_row(mk(ONE, ONE, 0, 0, 0), 1'b1, er);
        er = '0;
        add_row(mk(ONE, ONE, 16384, 0, 0), 1'b0, er);
        add_row(mk(ONE, ONE, 32768, 0, 0), 1'b0, er);
        add_row(mk(ONE, ONE, 49152, 0, 0), 1'b0, er);
        add_row(mk(ONE, ONE, 65535, 0, 0), 1'b0, er);
        add_row(mk(-ONE, ONE, 8192, ONE, -ONE), 1'b0, er);
        add_row(mk(24'sh7FFFFF, 24'sh7FFFFF, 8192, 24'sh7FFFFF, 24'sh7FFFFF), 1'b0, er);
        add_row(mk(-24'sh800000, -24'sh800000, 40960, -24'sh800000,
                   -24'sh800000), 1'b0, er);
        add_row(mk(24'sh7FFFFF, -24'sh800000, 24576, -24'sh800000,
                   24'sh7FFFFF), 1'b0, er);
        add_row(mk(-1, -1, 1, -1, -1), 1'b0, er);
        add_row(mk(1, 1, 16383, 1, 1), 1'b0, er);

        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, walked once per model (first pass under reset value)
        foreach (models[m]) begin
            if (m != 0) write_model(models[m]);
            foreach (rows[r]) begin
                send_item(rows[r].it);
                // Hand-typed expectations hold for the basic model only
                if (rows[r].has_exp && models[m] == MODEL_BASIC)
                    matrix_q[$] = rows[r].exp_r;
            end
        end

        // Random part: three idle phases, model changed between chunks
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 6 : (ph == 1) ? 47 : 0;
            for (int n = 0; n < N_RANDOM / 3; n++) begin
                if (n % 75 == 0) write_model(t_model'($urandom_range(3)));
                // Sender holds off until the pipe is empty, now and then
                if (n % 200 == 100) drain();
                it = rand_item();
                send_item(it);
            end
        end
        write_model(MODEL_TOOL3);
        send_item(rand_item());
        write_model(MODEL_BASIC);
        send_item(rand_item());

        drain();
        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/tsm_pkg.sv
rtl/tsm_front.sv
rtl/tsm_queue.sv
rtl/tsm_back.sv
rtl/texture_srt_matrix.sv
rtl/tsm_checker.sv
bench/texture_srt_matrix_tb.sv
